// ===== rtl/core/lpht_pkg.sv =====
package lpht_pkg;

    localparam logic [63:0] FIB_MULT = 64'd11400714819323198485;
    localparam int MIN_INDEX_BITS = 3;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_CREATED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        OP_FIND   = 1'b0,
        OP_CREATE = 1'b1
    } op_t;

endpackage

// ===== rtl/core/linear_probe_hash_table.sv =====
// Open-addressing table of 64-bit keys with Fibonacci hashing and linear
// probing. A request passes the hash stages s1 and s2 and is written into the
// queue; the probe sequencer then picks it up in S_IDLE, spends S_READ and
// S_CHECK on each probed slot (one slot memory read each) and hands over the
// result in S_DONE, where it waits while the output buffer is full. The front
// holds at most two requests ahead of the sequencer. After reset and after
// every index_bits write a clearing pass empties one slot per cycle over the
// 2^index_bits slots in use, while requests wait; the collision total is
// kept. Slot memories hold 2^MAX_INDEX_BITS entries.
module linear_probe_hash_table #(
    parameter int MAX_INDEX_BITS = 10,
    parameter int ACTION_BITS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [63:0] key,
    input  logic [7:0]  act_count,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [9:0]  slot_index,
    output logic [10:0] stored_count,
    output logic [31:0] collisions_seen,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);
    import lpht_pkg::*;

    localparam int BW = $clog2(MAX_INDEX_BITS+1);

    logic [3:0]   ib_reg;
    logic [BW-1:0] bits;
    logic q_valid, q_pop, q_op;
    logic [63:0] q_key;
    logic [ACTION_BITS-1:0] q_acts;
    logic [MAX_INDEX_BITS-1:0] q_home;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_reg <= 4'd10;
        end
        else if (cfg_we)
        begin
            ib_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (ib_reg < 4'(MIN_INDEX_BITS))
        begin
            bits = BW'(MIN_INDEX_BITS);
        end
        else if (32'(ib_reg) > MAX_INDEX_BITS)
        begin
            bits = BW'(MAX_INDEX_BITS);
        end
        else
        begin
            bits = BW'(ib_reg);
        end
    end

    lpht_front #(.MAX_INDEX_BITS(MAX_INDEX_BITS), .ACTION_BITS(ACTION_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .operation(operation),
        .key(key), .act_count(act_count), .bits(bits), .q_pop(q_pop),
        .q_valid(q_valid), .q_op(q_op), .q_key(q_key), .q_acts(q_acts), .q_home(q_home)
    );

    lpht_back #(.MAX_INDEX_BITS(MAX_INDEX_BITS), .ACTION_BITS(ACTION_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_clear(cfg_we), .bits(bits),
        .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_key(q_key), .q_acts(q_acts),
        .q_home(q_home), .empty(empty), .pop(pop), .status(status),
        .slot_index(slot_index), .stored_count(stored_count),
        .collisions_seen(collisions_seen)
    );

endmodule

// ===== rtl/core/lpht_ram.sv =====
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/lpht_front.sv =====
// Front: takes requests, computes the home slot over two multiply stages,
// and pushes into a two-entry queue.
module lpht_front #(
    parameter int MAX_INDEX_BITS = 10,
    parameter int ACTION_BITS    = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      operation,
    input  logic [63:0]               key,
    input  logic [7:0]                act_count,
    input  logic [$clog2(MAX_INDEX_BITS+1)-1:0] bits,
    input  logic                      q_pop,
    output logic                      q_valid,
    output logic                      q_op,
    output logic [63:0]               q_key,
    output logic [ACTION_BITS-1:0]    q_acts,
    output logic [MAX_INDEX_BITS-1:0] q_home
);
    import lpht_pkg::*;

    localparam int BW = $clog2(MAX_INDEX_BITS+1);

    logic                   s1_valid_reg;
    logic                   s1_op_reg;
    logic [63:0]            s1_key_reg;
    logic [ACTION_BITS-1:0] s1_acts_reg;
    logic [31:0]            p_ll_reg, p_lh_reg, p_hl_reg;
    logic [31:0]            p_ll_hi_reg;
    logic                   s2_valid_reg;
    logic                   s2_op_reg;
    logic [63:0]            s2_key_reg;
    logic [ACTION_BITS-1:0] s2_acts_reg;
    logic [63:0]            s2_prod_reg;
    logic [63:0]            prod_next;
    logic [MAX_INDEX_BITS-1:0] home_next;

    logic                      qo_reg [2];
    logic [63:0]               qk_reg [2];
    logic [ACTION_BITS-1:0]    qa_reg [2];
    logic [MAX_INDEX_BITS-1:0] qh_reg [2];
    logic                      wp_reg, rp_reg;
    logic [1:0]                cnt_reg;
    logic                      in_acc, q_push, q_do_pop;
    logic [2:0]                inflight;
    logic [63:0]               p_ll, p_lh, p_hl;

    assign inflight = {1'b0, cnt_reg} + {2'b0, s1_valid_reg} + {2'b0, s2_valid_reg};
    assign full = (inflight >= 3'd2);
    assign in_acc = push && !full;
    assign q_push = s2_valid_reg;
    assign q_do_pop = q_pop && cnt_reg != 2'd0;

    assign p_ll = {32'b0, key[31:0]} * {32'b0, FIB_MULT[31:0]};
    assign p_lh = {32'b0, key[31:0]} * {32'b0, FIB_MULT[63:32]};
    assign p_hl = {32'b0, key[63:32]} * {32'b0, FIB_MULT[31:0]};
    assign prod_next = {p_lh_reg + p_hl_reg + p_ll_hi_reg, p_ll_reg};

    always_comb
    begin
        home_next = '0;
        for (int b = MIN_INDEX_BITS; b <= MAX_INDEX_BITS; b++)
        begin
            if (bits == BW'(b))
            begin
                home_next = MAX_INDEX_BITS'(s2_prod_reg >> (64 - b));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            if (q_push)
            begin
                qo_reg[wp_reg] <= s2_op_reg;
                qk_reg[wp_reg] <= s2_key_reg;
                qa_reg[wp_reg] <= s2_acts_reg;
                qh_reg[wp_reg] <= home_next;
                wp_reg <= ~wp_reg;
            end
            if (q_do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, q_push} - {1'b0, q_do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg <= operation;
        s1_key_reg <= key;
        s1_acts_reg <= ACTION_BITS'(act_count);
        p_ll_reg <= p_ll[31:0];
        p_ll_hi_reg <= p_ll[63:32];
        p_lh_reg <= p_lh[31:0];
        p_hl_reg <= p_hl[31:0];
        s2_op_reg <= s1_op_reg;
        s2_key_reg <= s1_key_reg;
        s2_acts_reg <= s1_acts_reg;
        s2_prod_reg <= prod_next;
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_op = qo_reg[rp_reg];
    assign q_key = qk_reg[rp_reg];
    assign q_acts = qa_reg[rp_reg];
    assign q_home = qh_reg[rp_reg];

endmodule

// ===== rtl/core/lpht_back.sv =====
// Back: probe sequencer over the slot memories; the valid bit sits with the
// action count, and a clearing pass empties the slots in use.
module lpht_back #(
    parameter int MAX_INDEX_BITS = 10,
    parameter int ACTION_BITS    = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_clear,
    input  logic [$clog2(MAX_INDEX_BITS+1)-1:0] bits,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  logic                      q_op,
    input  logic [63:0]               q_key,
    input  logic [ACTION_BITS-1:0]    q_acts,
    input  logic [MAX_INDEX_BITS-1:0] q_home,
    output logic                      empty,
    input  logic                      pop,
    output logic [2:0]                status,
    output logic [9:0]                slot_index,
    output logic [10:0]               stored_count,
    output logic [31:0]               collisions_seen
);
    import lpht_pkg::*;

    localparam int DEPTH = 1 << MAX_INDEX_BITS;
    localparam int IW = MAX_INDEX_BITS;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DONE} state_t;

    state_t               state_reg;
    logic                 op_reg;
    logic [63:0]          key_reg;
    logic [ACTION_BITS-1:0] acts_reg;
    logic [IW-1:0]        slot_reg;
    logic [IW-1:0]        clr_reg;
    logic [IW:0]          probes_reg;
    logic [IW:0]          occ_reg;
    logic [31:0]          coll_reg;
    logic [IW-1:0]        mask;
    logic [IW:0]          cap, limit;
    logic [63:0]          rkey;
    logic [ACTION_BITS:0] rtag;
    logic                 rvalid;
    logic [ACTION_BITS-1:0] racts;
    logic                 ins;
    logic                 tag_we;
    logic [IW-1:0]        tag_waddr;
    logic [ACTION_BITS:0] tag_wdata;
    logic                 out_load;
    logic                 obuf_full_reg;
    status_t              st_reg;
    logic [IW-1:0]        oslot_reg;

    assign cap = (IW+1)'(1) << bits;
    assign mask = IW'(cap - 1'b1);
    assign limit = cap - (cap >> 2);
    assign rvalid = rtag[ACTION_BITS];
    assign racts = rtag[ACTION_BITS-1:0];
    assign ins = (state_reg == S_CHECK) && !rvalid && op_reg == OP_CREATE && (occ_reg < limit);
    assign tag_we = ins || (state_reg == S_CLEAR);
    assign tag_waddr = (state_reg == S_CLEAR) ? clr_reg : slot_reg;
    assign tag_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, acts_reg};
    assign q_pop = (state_reg == S_IDLE) && q_valid && !cfg_clear;
    assign out_load = (state_reg == S_DONE) && (!obuf_full_reg || pop);
    assign empty = !obuf_full_reg;

    lpht_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_key (
        .clk(clk), .we(ins), .waddr(slot_reg), .wdata(key_reg),
        .raddr(slot_reg), .rdata(rkey)
    );
    lpht_ram #(.WIDTH(ACTION_BITS+1), .DEPTH(DEPTH)) u_tag (
        .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
        .raddr(slot_reg), .rdata(rtag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            occ_reg <= '0;
            coll_reg <= '0;
            obuf_full_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                obuf_full_reg <= 1'b1;
            end
            else if (pop)
            begin
                obuf_full_reg <= 1'b0;
            end
            if (cfg_clear)
            begin
                state_reg <= S_CLEAR;
                clr_reg <= '0;
                occ_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == mask)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (q_valid)
                        begin
                            op_reg <= q_op;
                            key_reg <= q_key;
                            acts_reg <= q_acts;
                            slot_reg <= q_home & mask;
                            probes_reg <= '0;
                            if (q_op == OP_CREATE && q_acts == '0)
                            begin
                                st_reg <= ST_INVALID;
                                oslot_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_READ;
                            end
                        end
                    end
                    S_READ:
                    begin
                        state_reg <= S_CHECK;
                    end
                    S_CHECK:
                    begin
                        state_reg <= S_DONE;
                        oslot_reg <= '0;
                        if (!rvalid)
                        begin
                            if (op_reg == OP_FIND)
                            begin
                                st_reg <= ST_NOT_FOUND;
                            end
                            else if (occ_reg >= limit)
                            begin
                                st_reg <= ST_FULL;
                            end
                            else
                            begin
                                st_reg <= ST_CREATED;
                                oslot_reg <= slot_reg;
                                occ_reg <= occ_reg + 1'b1;
                            end
                        end
                        else if (rkey == key_reg)
                        begin
                            if (op_reg == OP_CREATE && racts != acts_reg)
                            begin
                                st_reg <= ST_INVALID;
                            end
                            else
                            begin
                                st_reg <= ST_FOUND;
                                oslot_reg <= slot_reg;
                            end
                        end
                        else
                        begin
                            if (coll_reg != '1)
                            begin
                                coll_reg <= coll_reg + 1'b1;
                            end
                            if (probes_reg + 1'b1 == cap)
                            begin
                                st_reg <= (op_reg == OP_FIND) ? ST_NOT_FOUND : ST_FULL;
                            end
                            else
                            begin
                                probes_reg <= probes_reg + 1'b1;
                                slot_reg <= (slot_reg + 1'b1) & mask;
                                state_reg <= S_READ;
                            end
                        end
                    end
                    S_DONE:
                    begin
                        if (out_load)
                        begin
                            status <= st_reg;
                            slot_index <= 10'(oslot_reg);
                            stored_count <= 11'(occ_reg);
                            collisions_seen <= coll_reg;
                            state_reg <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/lpht_checker.sv =====
module lpht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic [9:0]  slot_index,
    input logic [31:0] collisions_seen
);
    import lpht_pkg::*;

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= ST_FULL)) else $error("bad status");
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_NOT_FOUND || status == ST_FULL)) |-> slot_index == '0)
        else $error("slot not zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status))) else $error("result dropped");
    a_coll: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> (empty || collisions_seen >= $past(collisions_seen)))
        else $error("collisions went down");

endmodule

bind linear_probe_hash_table lpht_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .status(status),
    .slot_index(slot_index), .collisions_seen(collisions_seen)
);
